### hdl/humidity_sensor_frame_decoder_top_defines.svh
// Assertion macros shared by the frame decoder modules.
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_TOP_DEFINES_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_TOP_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define HSFD_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define HSFD_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### hdl/hsfd_pkg.sv
// Shared types, constants and the CRC step function for the frame decoder.
`timescale 1ns / 1ps

package hsfd_pkg;

    // CRC-8, MSB first, no final xor
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Byte positions within the six-byte frame
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // Conversion constants
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SPAN    = 14'd12500;
    localparam logic [13:0] HUM_OFFSET  = 14'd600;
    localparam logic [13:0] HUM_MAX     = 14'd10000;
    localparam logic [13:0] HUM_TOP     = 14'd10600;  // HUM_MAX + HUM_OFFSET

    // Frame queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One decoded frame: raw words and combined CRC flag
    typedef struct packed {
        logic [15:0] raw_t;
        logic [15:0] raw_h;
        logic        crc_error;
    } frame_t;

    // Push request from front to queue
    typedef struct packed {
        logic   valid;
        frame_t frame;
    } push_t;

    // One CRC-8 byte update
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

### hdl/humidity_sensor_frame_decoder_top.sv
// Path: the frame completed by the sixth byte goes through the frame queue, stage 1 and the output register.
// Throughput: one byte beat per cycle while s_tready is high, one result per six bytes;
// the two-entry frame queue and the two-stage conversion pipeline set this figure.
// s_tready drops only while the frame queue is full under output backpressure.
// Reset (rst_n, async, active low): byte position to 0, CRC to 0xFF, queue and pipeline empty.
`timescale 1ns / 1ps

module humidity_sensor_frame_decoder_top
    import hsfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi, zero pad
    output logic        m_tuser    // [0] crc_error
);

    push_t  push;
    logic   fifo_full;
    logic   q_valid;
    frame_t q_frame;
    logic   pop;

    hsfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .push      (push)
    );

    hsfd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (fifo_full),
        .q_valid (q_valid),
        .q_frame (q_frame),
        .pop     (pop)
    );

    hsfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_frame  (q_frame),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### hdl/hsfd_front.sv
// Front end: tracks byte position, checks CRCs and assembles frames.
`timescale 1ns / 1ps

module hsfd_front
    import hsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       s_tuser,   // [0] frame_start
    input  logic       fifo_full,
    output push_t      push
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  high_reg, high_next;
    logic [15:0] raw_t_reg, raw_t_next;
    logic [15:0] raw_h_reg, raw_h_next;
    logic        first_bad_reg, first_bad_next;
    logic [2:0]  pos_sel;
    logic        beat;

    assign s_tready = !fifo_full;
    assign beat     = s_tvalid && s_tready;

    // Byte decode and frame assembly
    always_comb
    begin
        pos_sel = s_tuser ? POS_T_HI : pos_reg;
        if (pos_sel > POS_H_CRC)
        begin
            pos_sel = POS_T_HI;
        end
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        high_next      = high_reg;
        raw_t_next     = raw_t_reg;
        raw_h_next     = raw_h_reg;
        first_bad_next = first_bad_reg;
        push.valid           = 1'b0;
        push.frame.raw_t     = raw_t_reg;
        push.frame.raw_h     = raw_h_reg;
        push.frame.crc_error = first_bad_reg | (crc_reg != s_tdata);
        if (beat)
        begin
            pos_next = pos_sel + 3'd1;
            unique case (pos_sel) inside
                POS_T_HI, POS_H_HI:
                begin
                    crc_next  = crc8_step(CRC_INIT, s_tdata);
                    high_next = s_tdata;
                end
                POS_T_LO:
                begin
                    raw_t_next = {high_reg, s_tdata};
                    crc_next   = crc8_step(crc_reg, s_tdata);
                end
                POS_H_LO:
                begin
                    raw_h_next = {high_reg, s_tdata};
                    crc_next   = crc8_step(crc_reg, s_tdata);
                end
                POS_T_CRC:
                begin
                    first_bad_next = (crc_reg != s_tdata);
                    crc_next       = CRC_INIT;
                end
                POS_H_CRC:
                begin
                    crc_next   = CRC_INIT;
                    pos_next   = POS_T_HI;
                    push.valid = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_HI;
            crc_reg       <= CRC_INIT;
            high_reg      <= 8'd0;
            raw_t_reg     <= 16'd0;
            raw_h_reg     <= 16'd0;
            first_bad_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            high_reg      <= high_next;
            raw_t_reg     <= raw_t_next;
            raw_h_reg     <= raw_h_next;
            first_bad_reg <= first_bad_next;
        end
    end

endmodule

### hdl/hsfd_fifo.sv
// Short frame queue between the front end and the conversion back end.
`timescale 1ns / 1ps
`include "humidity_sensor_frame_decoder_top_defines.svh"

module hsfd_fifo
    import hsfd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push,
    output logic   full,
    output logic   q_valid,
    output frame_t q_frame,
    input  logic   pop
);

    frame_t                entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign full    = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_frame = entry_reg[rd_ptr_reg];
    assign do_push = push.valid;
    assign do_pop  = pop && q_valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = FIFO_PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = FIFO_PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = FIFO_CNT_W'(count_reg + 1'b1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = FIFO_CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.frame;
        end
    end

    `HSFD_ASSERT_SAME(a_no_push_full, do_push, !full, "frame pushed into full queue")
    `HSFD_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1, "queue count did not rise")
    `HSFD_ASSERT_NEXT(a_count_down, !do_push && do_pop, count_reg == $past(count_reg) - 1'b1, "queue count did not fall")

endmodule

### hdl/hsfd_back.sv
// Back end: scales raw words to centi-units and drives the result stream.
`timescale 1ns / 1ps
`include "humidity_sensor_frame_decoder_top_defines.svh"

module hsfd_back
    import hsfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  frame_t      q_frame,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [14:0] temperature_centi, [28:15] humidity_centi, zero pad
    output logic        m_tuser   // [0] crc_error
);

    logic        s1_valid_reg;
    logic [30:0] s1_prod_t_reg, s1_prod_t_next;
    logic [29:0] s1_prod_h_reg, s1_prod_h_next;
    logic        s1_err_reg;
    logic        out_valid_reg;
    logic [14:0] temp_reg, temp_next;
    logic [13:0] hum_reg, hum_next;
    logic        err_reg;
    logic        out_move, s1_move;
    logic [31:0] sum_t;
    logic [29:0] sum_h;
    logic [14:0] q_t;
    logic [13:0] q_h;

    // Stage advance: a stage moves when its successor is empty or draining
    assign out_move = !out_valid_reg || m_tready;
    assign s1_move  = !s1_valid_reg || out_move;
    assign pop      = q_valid && s1_move;

    // Stage 1: constant multiplies
    assign s1_prod_t_next = 31'(q_frame.raw_t) * 31'(TEMP_SPAN);
    assign s1_prod_h_next = 30'(q_frame.raw_h) * 30'(HUM_SPAN);

    // Stage 2: divide by 65535 as (x + (x >> 16) + 1) >> 16, exact for quotients below 2^16
    always_comb
    begin
        sum_t = {1'b0, s1_prod_t_reg} + 32'(s1_prod_t_reg >> 16) + 32'd1;
        sum_h = s1_prod_h_reg + 30'(s1_prod_h_reg >> 16) + 30'd1;
        q_t   = sum_t[30:16];
        q_h   = sum_h[29:16];
        temp_next = q_t - TEMP_OFFSET;
        if (q_h < HUM_OFFSET)
        begin
            hum_next = 14'd0;
        end
        else if (q_h > HUM_TOP)
        begin
            hum_next = HUM_MAX;
        end
        else
        begin
            hum_next = q_h - HUM_OFFSET;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                s1_valid_reg <= q_valid;
            end
            if (out_move)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_prod_t_reg <= s1_prod_t_next;
            s1_prod_h_reg <= s1_prod_h_next;
            s1_err_reg    <= q_frame.crc_error;
        end
        if (out_move && s1_valid_reg)
        begin
            temp_reg <= temp_next;
            hum_reg  <= hum_next;
            err_reg  <= s1_err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, hum_reg, temp_reg};
    assign m_tuser  = err_reg;

    `HSFD_ASSERT_SAME(a_hum_range, out_valid_reg, hum_reg <= HUM_MAX, "humidity above clamp")
    `HSFD_ASSERT_SAME(a_temp_range, out_valid_reg, ($signed(temp_reg) >= -15'sd4500) && ($signed(temp_reg) <= 15'sd13000), "temperature out of range")
    `HSFD_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !out_move, s1_valid_reg && $stable(s1_prod_t_reg), "stage 1 lost data while stalled")

endmodule

### bench/testbench.sv
// Self-checking bench for the humidity/temperature frame decoder: CRC and conversion checks.
`timescale 1ns / 1ps

module testbench;
    import hsfd_pkg::*;

    localparam int          FULL_SCALE   = 65535;
    localparam int          LIMIT_CYCLES = 200000;
    localparam int          RAND_ITEMS   = 450;
    localparam int          CALM_ITEMS   = 90;   // final stretch without idling
    localparam int          DRAIN_CYCLES = 12;

    // One expected reading
    typedef struct {
        logic [14:0] temp_centi;
        logic [13:0] hum_centi;
        logic        crc_bad;
    } reading_t;

    // CRC-8, poly 0x31, MSB first
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       msb;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            msb = c[7];
            c   = {c[6:0], 1'b0};
            if (msb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // Predicts readings from accepted bytes and checks output beats
    class frame_scoreboard;
        logic [2:0]  pos;
        logic [7:0]  crc;
        logic [7:0]  hi_byte;
        logic [15:0] raw_t;
        logic [15:0] raw_h;
        logic        bad_t;
        reading_t    expected_readings[$];
        int          errors;

        function new();
            pos     = POS_T_HI;
            crc     = CRC_INIT;
            hi_byte = '0;
            raw_t   = '0;
            raw_h   = '0;
            bad_t   = 1'b0;
            errors  = 0;
        endfunction

        function void note_byte(logic [7:0] b, logic mark);
            logic [2:0] p;
            reading_t   r;
            longint     t;
            longint     h;
            p = mark ? POS_T_HI : pos;
            if (p > POS_H_CRC)
                p = POS_T_HI;
            case (p)
                POS_T_HI, POS_H_HI:
                begin
                    crc     = crc_update(CRC_INIT, b);
                    hi_byte = b;
                end
                POS_T_LO:
                begin
                    raw_t = {hi_byte, b};
                    crc   = crc_update(crc, b);
                end
                POS_H_LO:
                begin
                    raw_h = {hi_byte, b};
                    crc   = crc_update(crc, b);
                end
                POS_T_CRC:
                begin
                    bad_t = (crc != b);
                    crc   = CRC_INIT;
                end
                default:
                begin
                end
            endcase
            if (p != POS_H_CRC)
            begin
                pos = p + 3'd1;
                return;
            end
            // last byte of the frame: build the reading
            t = (longint'(TEMP_SPAN) * raw_t) / FULL_SCALE - longint'(TEMP_OFFSET);
            h = (longint'(HUM_SPAN) * raw_h) / FULL_SCALE - longint'(HUM_OFFSET);
            if (h < 0)
                h = 0;
            else if (h > longint'(HUM_MAX))
                h = HUM_MAX;
            r.temp_centi = t[14:0];
            r.hum_centi  = h[13:0];
            r.crc_bad    = bad_t | (crc != b);
            expected_readings.push_back(r);
            crc = CRC_INIT;
            pos = POS_T_HI;
        endfunction

        function void check_reading(logic [31:0] data, logic flag);
            reading_t r;
            if (expected_readings.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual data %h user %b",
                         $time, data, flag);
                errors++;
                return;
            end
            r = expected_readings.pop_front();
            if (data[14:0] !== r.temp_centi)
            begin
                $display("%0t: temperature mismatch, expected %0d actual %0d", $time,
                         $signed(r.temp_centi), $signed(data[14:0]));
                errors++;
            end
            if (data[28:15] !== r.hum_centi)
            begin
                $display("%0t: humidity mismatch, expected %0d actual %0d", $time,
                         r.hum_centi, data[28:15]);
                errors++;
            end
            if (data[31:29] !== 3'b000)
            begin
                $display("%0t: pad bits mismatch, expected 0 actual %b", $time, data[31:29]);
                errors++;
            end
            if (flag !== r.crc_bad)
            begin
                $display("%0t: crc flag mismatch, expected %b actual %b", $time,
                         r.crc_bad, flag);
                errors++;
            end
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    frame_scoreboard sb;
    bit              idle_on;
    int              stall_left;
    int              cycles;
    int              items_sent;

    humidity_sensor_frame_decoder_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_byte(s_tdata, s_tuser);
        if (rst_n && m_tvalid && m_tready)
            sb.check_reading(m_tdata, m_tuser);
    end

    // Receiver backpressure in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   = 1'b0;
            stall_left = stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            m_tready   = 1'b0;
            stall_left = $urandom_range(1, 5) - 1;
        end
        else
            m_tready = 1'b1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("humidity_sensor_frame_decoder_top regression: fail");
            $finish;
        end
    end

    // Present one byte beat and wait for its acceptance; called at a falling edge
    task automatic send_beat(input logic [7:0] b, input logic mark);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = mark;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        s_tvalid   = 1'b0;
        items_sent = items_sent + 1;
    endtask

    // Send the first nbytes of a frame; CRC bytes correct unless flagged bad
    task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                              input bit t_good, input bit h_good, input bit mark,
                              input int nbytes);
        logic [7:0] frame_bytes[6];
        logic [7:0] c;
        c = crc_update(crc_update(CRC_INIT, t_word[15:8]), t_word[7:0]);
        frame_bytes[0] = t_word[15:8];
        frame_bytes[1] = t_word[7:0];
        frame_bytes[2] = t_good ? c : c ^ 8'($urandom_range(1, 255));
        c = crc_update(crc_update(CRC_INIT, h_word[15:8]), h_word[7:0]);
        frame_bytes[3] = h_word[15:8];
        frame_bytes[4] = h_word[7:0];
        frame_bytes[5] = h_good ? c : c ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < nbytes; i++)
            send_beat(frame_bytes[i], (i == 0) ? mark : 1'b0);
    endtask

    // Random word, biased toward the ends and the clamp regions
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 3300));
            3:       return 16'($urandom_range(55400, 65535));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Stimulus
    initial
    begin
        int  kind;
        bit  calm;
        sb         = new();
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        idle_on    = 1'b0;
        stall_left = 0;
        cycles     = 0;
        items_sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: low extremes with humidity clamped to zero
        send_frame(16'h0000, 16'h0000, 1, 1, 1, 6);
        // Full scale, humidity clamped to the top, back to back with no marker
        send_frame(16'hFFFF, 16'hFFFF, 1, 1, 0, 6);
        // Partial frame dropped by a new frame start, bad temperature CRC
        send_frame(16'h1234, 16'h5678, 1, 1, 1, 2);
        send_frame(16'h6666, 16'h8000, 0, 1, 1, 6);
        // Bad humidity CRC, values still reported
        send_frame(16'hA5C3, 16'h3C5A, 1, 0, 1, 6);

        // Random: mostly well-formed frames, some noise and broken frames
        idle_on = 1'b1;
        while (items_sent < RAND_ITEMS + 26)
        begin
            calm = (items_sent >= RAND_ITEMS + 26 - CALM_ITEMS);
            if (calm)
                idle_on = 1'b0;
            kind = $urandom_range(0, 19);
            if (kind < 2)
                send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (kind < 4)
                send_frame(pick_word(), pick_word(), 1, 1, 1, $urandom_range(1, 5));
            else
                send_frame(pick_word(), pick_word(), $urandom_range(0, 4) != 0,
                           $urandom_range(0, 4) != 0, $urandom_range(0, 1), 6);
        end
        // Close any open partial frame so its tail leaves no pending state
        send_frame(pick_word(), pick_word(), 1, 1, 1, 6);

        // Drain
        idle_on = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("humidity_sensor_frame_decoder_top regression: pass");
        else
            $display("humidity_sensor_frame_decoder_top regression: fail");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/hsfd_pkg.sv
hdl/hsfd_front.sv
hdl/hsfd_fifo.sv
hdl/hsfd_back.sv
hdl/humidity_sensor_frame_decoder_top.sv
bench/testbench.sv
